### rtl/core/qpg_pkg.sv
// qpg_pkg: shared types and constants for the quaternion pose guard
// depends on: nothing
package qpg_pkg;

	// component and squared-norm widths
	localparam int unsigned COMP_W = 16;
	localparam int unsigned MUL_W  = 18;
	localparam int unsigned PROD_W = 2 * MUL_W;
	localparam int unsigned S_W    = 33;
	localparam int unsigned SQ_W   = 32;
	localparam int unsigned ERR_W  = 15;
	localparam int unsigned BND_W  = 34;
	localparam int unsigned DOT_W  = 33;

	// width of the square-root-divide accumulators
	localparam int unsigned ACC_W = 68;

	// digits of one scaled magnitude, one per cycle
	localparam int unsigned SCALE_STEPS = 15;

	localparam logic [ERR_W-1:0]  MAX_ERR_RESET = 15'd6554;
	localparam logic signed [COMP_W-1:0] Q_ONE  = 16'sd16384;
	localparam logic [16:0]       NORM_ONE      = 17'd65536;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

endpackage

### rtl/core/quaternion_pose_guard_top.sv
// quaternion_pose_guard_top: norm check, unit scaling and hemisphere continuity
// for a stream of signed Q2.14 orientation quaternions
// depends on: qpg_pkg
//
// usage
//   input channel: in_valid / in_stall with in_w, in_x, in_y, in_z (signed Q2.14)
//   output channel: out_valid / out_stall with out_w..out_z, pose_valid, pose_held
//   a transaction moves when valid is high and stall is low at a rising clk edge
//   cfg_wr_en / cfg_wr_data write max_norm_error (unsigned Q0.16); write only when idle
//   one transaction is worked on at a time; in_stall is high from the accept
//   until the result is loaded into the output register
//   from the accept: four component squares and two bound squares, the check, four
//   components of 15 digits each, the dot product and the load; the first accepted
//   pose skips the dot product, a rejected pose goes from check to load; scaling is
//   digit-serial, one result bit per cycle; a next input can come the cycle after load
//   the output register parts the channels: a finished result may wait on
//   out_stall while the next input is taken; the block waits at load time only
//   if the previous result is still stalled
//   reset: identity pose stored, no accepted pose, max_norm_error = 6554,
//   output channel empty
module quaternion_pose_guard_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [15:0]             in_w,
	input  logic signed [15:0]             in_x,
	input  logic signed [15:0]             in_y,
	input  logic signed [15:0]             in_z,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [15:0]             out_w,
	output logic signed [15:0]             out_x,
	output logic signed [15:0]             out_y,
	output logic signed [15:0]             out_z,
	output logic                           pose_valid,
	output logic                           pose_held,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [qpg_pkg::ERR_W-1:0]      cfg_wr_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_CHECK,
		ST_SCALE,
		ST_DOT,
		ST_FINISH
	} state_t;

	// counter positions in the norm and dot sequences
	localparam logic [2:0] CNT_LO   = 3'd4;  // lower bound square issued
	localparam logic [2:0] CNT_HI   = 3'd5;  // upper bound square issued
	localparam logic [2:0] CNT_NEND = 3'd6;  // last norm product taken
	localparam logic [2:0] CNT_DEND = 3'd4;  // last dot product taken
	localparam logic [3:0] STEP_LAST = 4'(qpg_pkg::SCALE_STEPS - 1);
	localparam logic [1:0] COMP_LAST = 2'd3;

	// control state
	state_t                        state_q;
	logic [2:0]                    cnt_q;
	logic [3:0]                    step_q;
	logic [1:0]                    comp_q;
	logic [qpg_pkg::ERR_W-1:0]     max_err_q;
	qpg_pkg::comp_t                last_q [4];
	logic                          have_pose_q;

	// output register
	logic                          out_valid_q;
	qpg_pkg::comp_t                out_q [4];
	logic                          pose_valid_q;
	logic                          pose_held_q;

	// datapath registers
	qpg_pkg::comp_t                q_q [4];       // candidate, rotates through slot 0
	logic [qpg_pkg::SQ_W-1:0]      sq_q [4];      // component squares, rotate with q_q
	logic [qpg_pkg::S_W-1:0]       s_q;           // squared norm, unsigned Q5.28
	logic [qpg_pkg::BND_W-1:0]     lo2_q;
	logic [qpg_pkg::BND_W-1:0]     hi2_q;
	logic signed [qpg_pkg::PROD_W-1:0] prod_q;    // shared multiplier output
	logic                          reject_q;
	qpg_pkg::acc_t                 t_q;           // (2m-1)^2 * S for accepted digits
	qpg_pkg::acc_t                 w_q;           // (2m-1) * S aligned to current digit
	qpg_pkg::acc_t                 g_q;           // S aligned to current digit squared
	qpg_pkg::acc_t                 target_q;      // c^2 << 30
	logic [14:0]                   m_q;           // magnitude digits so far
	qpg_pkg::comp_t                r_q [4];       // scaled result, shifts in at slot 3
	logic signed [qpg_pkg::DOT_W-1:0] dot_q;

	// handshakes
	logic in_fire;
	logic out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// shared multiplier operands
	logic [16:0]                   lo_bnd;
	logic [16:0]                   hi_bnd;
	logic signed [qpg_pkg::MUL_W-1:0] mul_a;
	logic signed [qpg_pkg::MUL_W-1:0] mul_b;

	assign lo_bnd = qpg_pkg::NORM_ONE - {2'b00, max_err_q};
	assign hi_bnd = qpg_pkg::NORM_ONE + {2'b00, max_err_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_NORM: begin
				if (cnt_q == CNT_LO) begin
					mul_a = {1'b0, lo_bnd};
					mul_b = {1'b0, lo_bnd};
				end else if (cnt_q == CNT_HI) begin
					mul_a = {1'b0, hi_bnd};
					mul_b = {1'b0, hi_bnd};
				end else begin
					mul_a = {{2{q_q[0][15]}}, q_q[0]};
					mul_b = {{2{q_q[0][15]}}, q_q[0]};
				end
			end
			ST_DOT: begin
				mul_a = {{2{last_q[0][15]}}, last_q[0]};
				mul_b = {{2{r_q[0][15]}}, r_q[0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// norm window test: reject zero or (65536-E)^2 > 16S or 16S > (65536+E)^2
	logic [qpg_pkg::S_W+3:0] s16;
	logic                    norm_bad;

	assign s16      = {s_q, 4'd0};
	assign norm_bad = (s_q == '0) || (s16 < {3'd0, lo2_q}) || (s16 > {3'd0, hi2_q});

	// scaling unit start values for one component
	qpg_pkg::acc_t s_ext;
	qpg_pkg::acc_t w_init;
	qpg_pkg::acc_t g_init;

	assign s_ext  = {{(qpg_pkg::ACC_W - qpg_pkg::S_W){1'b0}}, s_q};
	assign w_init = -(s_ext <<< 16);
	assign g_init = s_ext <<< 30;

	// one digit: try setting the current bit of m, keep it if (2m-1)^2 S <= c^2 2^30
	qpg_pkg::acc_t cand;
	logic          digit;
	logic [14:0]   m_fin;
	qpg_pkg::comp_t mag;

	assign cand  = t_q + w_q + g_q;
	assign digit = (cand <= target_q);
	assign m_fin = {m_q[13:0], digit};
	assign mag   = {1'b0, m_fin};

	// hemisphere flip
	logic           flip;
	qpg_pkg::comp_t r_fin [4];

	assign flip = have_pose_q && dot_q[qpg_pkg::DOT_W-1];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			r_fin[i] = flip ? -r_q[i] : r_q[i];
		end
	end

	// sequencer, configuration, stored pose and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			step_q       <= '0;
			comp_q       <= '0;
			max_err_q    <= qpg_pkg::MAX_ERR_RESET;
			last_q[0]    <= qpg_pkg::Q_ONE;
			last_q[1]    <= '0;
			last_q[2]    <= '0;
			last_q[3]    <= '0;
			have_pose_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q[0]     <= '0;
			out_q[1]     <= '0;
			out_q[2]     <= '0;
			out_q[3]     <= '0;
			pose_valid_q <= 1'b0;
			pose_held_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_err_q <= cfg_wr_data;
			end
			// the finish state loads the register itself
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_NORM;
						cnt_q   <= '0;
					end
				end
				ST_NORM: begin
					if (cnt_q == CNT_NEND) begin
						state_q <= ST_CHECK;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_CHECK: begin
					step_q <= '0;
					comp_q <= '0;
					state_q <= norm_bad ? ST_FINISH : ST_SCALE;
				end
				ST_SCALE: begin
					if (step_q == STEP_LAST) begin
						step_q <= '0;
						if (comp_q == COMP_LAST) begin
							cnt_q   <= '0;
							state_q <= have_pose_q ? ST_DOT : ST_FINISH;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_DOT: begin
					if (cnt_q < CNT_DEND) begin
						// rotate the stored pose past the multiplier, back in place after four
						last_q[0] <= last_q[1];
						last_q[1] <= last_q[2];
						last_q[2] <= last_q[3];
						last_q[3] <= last_q[0];
					end
					if (cnt_q == CNT_DEND) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (reject_q) begin
							// hold the last pose, or show identity when none exists
							for (int i = 0; i < 4; i++) begin
								out_q[i] <= have_pose_q ? last_q[i] :
									((i == 0) ? qpg_pkg::Q_ONE : '0);
							end
							pose_valid_q <= have_pose_q;
							pose_held_q  <= have_pose_q;
						end else begin
							for (int i = 0; i < 4; i++) begin
								out_q[i]  <= r_fin[i];
								last_q[i] <= r_fin[i];
							end
							have_pose_q  <= 1'b1;
							pose_valid_q <= 1'b1;
							pose_held_q  <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					q_q[0] <= in_w;
					q_q[1] <= in_x;
					q_q[2] <= in_y;
					q_q[3] <= in_z;
					s_q    <= '0;
				end
			end
			ST_NORM: begin
				if (cnt_q < CNT_LO) begin
					q_q[0] <= q_q[1];
					q_q[1] <= q_q[2];
					q_q[2] <= q_q[3];
					q_q[3] <= q_q[0];
				end
				// squares arrive in the cycle after issue, from the product register
				if (cnt_q != '0 && cnt_q <= CNT_LO) begin
					s_q     <= s_q + {1'b0, prod_q[qpg_pkg::SQ_W-1:0]};
					sq_q[0] <= sq_q[1];
					sq_q[1] <= sq_q[2];
					sq_q[2] <= sq_q[3];
					sq_q[3] <= prod_q[qpg_pkg::SQ_W-1:0];
				end
				if (cnt_q == CNT_HI) begin
					lo2_q <= prod_q[qpg_pkg::BND_W-1:0];
				end
				if (cnt_q == CNT_NEND) begin
					hi2_q <= prod_q[qpg_pkg::BND_W-1:0];
				end
			end
			ST_CHECK: begin
				reject_q <= norm_bad;
				t_q      <= s_ext;
				w_q      <= w_init;
				g_q      <= g_init;
				target_q <= {{(qpg_pkg::ACC_W - qpg_pkg::SQ_W - 30){1'b0}}, sq_q[0], 30'd0};
				m_q      <= '0;
			end
			ST_SCALE: begin
				if (step_q == STEP_LAST) begin
					r_q[0] <= r_q[1];
					r_q[1] <= r_q[2];
					r_q[2] <= r_q[3];
					r_q[3] <= q_q[0][15] ? -mag : mag;
					q_q[0] <= q_q[1];
					q_q[1] <= q_q[2];
					q_q[2] <= q_q[3];
					q_q[3] <= q_q[0];
					sq_q[0] <= sq_q[1];
					sq_q[1] <= sq_q[2];
					sq_q[2] <= sq_q[3];
					sq_q[3] <= sq_q[0];
					// restart the unit on the next component
					t_q      <= s_ext;
					w_q      <= w_init;
					g_q      <= g_init;
					target_q <= {{(qpg_pkg::ACC_W - qpg_pkg::SQ_W - 30){1'b0}}, sq_q[1], 30'd0};
					m_q      <= '0;
					dot_q    <= '0;
				end else begin
					if (digit) begin
						t_q <= cand;
						w_q <= (w_q >>> 1) + g_q;
					end else begin
						w_q <= w_q >>> 1;
					end
					g_q <= g_q >>> 2;
					m_q <= m_fin;
				end
			end
			ST_DOT: begin
				if (cnt_q < CNT_DEND) begin
					r_q[0] <= r_q[1];
					r_q[1] <= r_q[2];
					r_q[2] <= r_q[3];
					r_q[3] <= r_q[0];
				end
				if (cnt_q != '0) begin
					dot_q <= dot_q + prod_q[qpg_pkg::DOT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_w      = out_q[0];
	assign out_x      = out_q[1];
	assign out_y      = out_q[2];
	assign out_z      = out_q[3];
	assign pose_valid = pose_valid_q;
	assign pose_held  = pose_held_q;

	// a held pose is always a valid one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pose_held |-> pose_valid)
		else $error("held pose reported without a valid pose");

	// an accepted candidate is stored and shown as a fresh pose
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && out_free && !reject_q
		|=> have_pose_q && out_valid && pose_valid && !pose_held)
		else $error("accepted pose not stored or not shown");

	// the scaled magnitude never exceeds one in Q2.14
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCALE && step_q == STEP_LAST |-> m_fin <= 15'd16384)
		else $error("scaled magnitude above unit");

	// every valid pose has components within the unit range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pose_valid |->
		out_w <= 16'sd16384 && out_w >= -16'sd16384 &&
		out_x <= 16'sd16384 && out_x >= -16'sd16384 &&
		out_y <= 16'sd16384 && out_y >= -16'sd16384 &&
		out_z <= 16'sd16384 && out_z >= -16'sd16384)
		else $error("pose component outside unit range");

endmodule
